// ===== hdl/utf8_char_assembler_validator_defines.svh =====
// Assertion macros shared by the UTF-8 assembler and validator RTL.
// Standalone header with no dependencies; the assertions compile away under SYNTHESIS.
`ifndef UTF8_CHAR_ASSEMBLER_VALIDATOR_DEFINES_SVH
`define UTF8_CHAR_ASSEMBLER_VALIDATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define U8CAV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define U8CAV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define U8CAV_ASSERT(lbl, clk, rst, prop, msg)
`define U8CAV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/u8cav_pkg.sv =====
// Types, constants and decode functions for the UTF-8 assembler and validator.
// Has no dependencies; the assembler, the result register and the top level import it.
`timescale 1ns / 1ps
package u8cav_pkg;

  localparam logic [31:0] ASCII_MAX   = 32'h0000_007F;
  localparam logic [31:0] TWO_MIN     = 32'h0000_C280;
  localparam logic [31:0] TWO_MAX     = 32'h0000_DFBF;
  localparam logic [31:0] TWO_MASK    = 32'h0000_E0C0;
  localparam logic [31:0] TWO_PAT     = 32'h0000_C080;
  localparam logic [31:0] SURR_MIN    = 32'h00ED_A080;
  localparam logic [31:0] SURR_MAX    = 32'h00ED_BFBF;
  localparam logic [31:0] THREE_MIN   = 32'h00E0_A080;
  localparam logic [31:0] THREE_MAX   = 32'h00EF_BFBF;
  localparam logic [31:0] THREE_MASK  = 32'h00F0_C0C0;
  localparam logic [31:0] THREE_PAT   = 32'h00E0_8080;
  localparam logic [31:0] FOUR_MIN    = 32'hF090_8080;
  localparam logic [31:0] FOUR_MAX    = 32'hF48F_BFBF;
  localparam logic [31:0] FOUR_MASK   = 32'hF8C0_C0C0;
  localparam logic [31:0] FOUR_PAT    = 32'hF080_8080;

  typedef struct packed {
    logic        emit;
    logic [31:0] word;
    logic [2:0]  count;
    logic        ok;
  } res_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    unique case (b[7:4]) inside
      [4'h0:4'h7]: len = 3'd1;
      [4'h8:4'hB]: len = 3'd0;
      4'hC, 4'hD:  len = 3'd2;
      4'hE:        len = 3'd3;
      default:     len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic word_valid(input logic [31:0] w);
    logic ok;
    if (w <= ASCII_MAX) begin
      ok = 1'b1;
    end else if (w >= TWO_MIN && w <= TWO_MAX) begin
      ok = ((w & TWO_MASK) == TWO_PAT);
    end else if (w >= SURR_MIN && w <= SURR_MAX) begin
      ok = 1'b0;
    end else if (w >= THREE_MIN && w <= THREE_MAX) begin
      ok = ((w & THREE_MASK) == THREE_PAT);
    end else if (w >= FOUR_MIN && w <= FOUR_MAX) begin
      ok = ((w & FOUR_MASK) == FOUR_PAT);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// ===== hdl/u8cav_in_stage.sv =====
// Input register of the UTF-8 assembler: holds one byte until the assembler takes it.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
module u8cav_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_in,
  input  logic       consume,
  output logic       a_valid,
  output logic [7:0] a_byte
);

  assign in_stall = a_valid && !consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_byte <= byte_in;
    end
  end

endmodule

// ===== hdl/u8cav_assembler.sv =====
// Sequence tracker: decodes lead bytes, gathers following bytes and checks the word.
// Depends on u8cav_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "utf8_char_assembler_validator_defines.svh"
module u8cav_assembler
  import u8cav_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       a_valid,
  input  logic [7:0] a_byte,
  input  logic       b_free,
  output logic       consume,
  output res_t       res
);

  logic [1:0]  bytes_pending;
  logic [1:0]  bytes_pending_next;
  logic [23:0] partial_word;
  logic [23:0] partial_word_next;
  logic [2:0]  sequence_length;
  logic [2:0]  sequence_length_next;
  logic [2:0]  lead_len;
  logic [31:0] joined;
  logic [1:0]  pending_dec;

  assign lead_len    = lead_length(a_byte);
  assign joined      = {partial_word, a_byte};
  assign pending_dec = bytes_pending - 2'd1;

  always_comb begin
    bytes_pending_next   = bytes_pending;
    partial_word_next    = partial_word;
    sequence_length_next = sequence_length;
    res.emit  = 1'b0;
    res.word  = joined;
    res.count = sequence_length;
    if (bytes_pending == 2'd0) begin
      if (lead_len <= 3'd1) begin
        res.emit  = 1'b1;
        res.word  = {24'd0, a_byte};
        res.count = 3'd1;
      end else begin
        partial_word_next    = {16'd0, a_byte};
        bytes_pending_next   = lead_len[1:0] - 2'd1;
        sequence_length_next = lead_len;
      end
    end else if (pending_dec != 2'd0) begin
      partial_word_next  = joined[23:0];
      bytes_pending_next = pending_dec;
    end else begin
      res.emit             = 1'b1;
      partial_word_next    = 24'd0;
      sequence_length_next = 3'd0;
      bytes_pending_next   = 2'd0;
    end
    res.ok = word_valid(res.word);
  end

  assign consume = a_valid && (b_free || !res.emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending   <= 2'd0;
      partial_word    <= 24'd0;
      sequence_length <= 3'd0;
    end else if (consume) begin
      bytes_pending   <= bytes_pending_next;
      partial_word    <= partial_word_next;
      sequence_length <= sequence_length_next;
    end
  end

  `U8CAV_ASSERT(a_idle_match, clk, rst, ((bytes_pending == 2'd0) == (sequence_length == 3'd0)), "Pending count and sequence length disagree on an open sequence.")
  `U8CAV_ASSERT_IMPL(a_pending_bound, clk, rst, bytes_pending != 2'd0, {1'b0, bytes_pending} < sequence_length, "More bytes pending than the sequence length allows.")
  `U8CAV_ASSERT(a_open_after_lead, clk, rst, ((consume && !res.emit) |=> (bytes_pending != 2'd0)), "A byte without a result left no sequence open.")

endmodule

// ===== hdl/u8cav_out_stage.sv =====
// Result register of the UTF-8 assembler; it frees as soon as the consumer takes a result.
// Depends on u8cav_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "utf8_char_assembler_validator_defines.svh"
module u8cav_out_stage
  import u8cav_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        consume,
  input  res_t        res,
  output logic        b_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] code_word,
  output logic [2:0]  byte_count,
  output logic        is_valid
);

  logic load;

  assign b_free = !out_valid || !out_stall;
  assign load   = consume && res.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && b_free) begin
      code_word  <= res.word;
      byte_count <= res.count;
      is_valid   <= res.ok;
    end
  end

  `U8CAV_ASSERT_IMPL(a_count_range, clk, rst, out_valid, byte_count >= 3'd1 && byte_count <= 3'd4, "Result byte count out of range.")
  `U8CAV_ASSERT_IMPL(a_single_width, clk, rst, out_valid && byte_count == 3'd1, code_word[31:8] == 24'd0, "One-byte result carries upper bits.")
  `U8CAV_ASSERT_IMPL(a_ascii_only, clk, rst, out_valid && is_valid && byte_count == 3'd1, code_word[7] == 1'b0, "Valid one-byte result is not ASCII.")
  `U8CAV_ASSERT_IMPL(a_four_lead, clk, rst, out_valid && is_valid && byte_count == 3'd4, code_word[31:28] == 4'hF, "Valid four-byte result lacks a four-byte lead.")

endmodule

// ===== hdl/utf8_char_assembler_validator.sv =====
// Top level of the UTF-8 byte assembler and validator.
// Depends on u8cav_pkg, u8cav_in_stage, u8cav_assembler and u8cav_out_stage.
`timescale 1ns / 1ps
// The block takes one byte per clock unless stalled; the byte that ends a sequence passes
// through the input register and the result register. An ASCII byte or a stray continuation
// byte yields a one-byte result at once, while a lead byte opens a sequence of two to four
// bytes whose packed word, byte count and validity flag appear after its last byte. Bytes
// following a lead are taken as part of that sequence whatever their value; a bad byte only
// clears is_valid. An input register feeds a single pass of decode, shift and range compare
// into a result register, so a new byte is accepted every cycle as long as that register can drain.
module utf8_char_assembler_validator
  import u8cav_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] code_word,
  output logic [2:0]  byte_count,
  output logic        is_valid
);

  logic       a_valid;
  logic [7:0] a_byte;
  logic       consume;
  logic       b_free;
  res_t       res;

  u8cav_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .byte_in  (byte_in),
    .consume  (consume),
    .a_valid  (a_valid),
    .a_byte   (a_byte)
  );

  u8cav_assembler u_asm (
    .clk     (clk),
    .rst     (rst),
    .a_valid (a_valid),
    .a_byte  (a_byte),
    .b_free  (b_free),
    .consume (consume),
    .res     (res)
  );

  u8cav_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .consume    (consume),
    .res        (res),
    .b_free     (b_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_word  (code_word),
    .byte_count (byte_count),
    .is_valid   (is_valid)
  );

endmodule
